// ----- design/diff_drive_odometry_step_core_defines.svh -----
// Assertion macros shared by the odometry step checker.
`ifndef DIFF_DRIVE_ODOMETRY_STEP_CORE_DEFINES_SVH
`define DIFF_DRIVE_ODOMETRY_STEP_CORE_DEFINES_SVH

// Check that cons holds in the cycle after ante.
`define DDO_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Check that cons holds in the same cycle as ante.
`define DDO_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- design/ddo_pkg.sv -----
// Package: types, constants and helper functions of the odometry step block.
`default_nettype none
package ddo_pkg;

  localparam int CORDIC_STEPS  = 16;
  localparam int POSITION_BITS = 40;
  localparam int ATAN_COUNT    = 24;
  localparam int ROT_STEPS     = (CORDIC_STEPS < ATAN_COUNT) ? CORDIC_STEPS : ATAN_COUNT;
  localparam int STEP_W        = $clog2(ATAN_COUNT);

  localparam int POS_OUT_W = 40;
  localparam int STEP_OUT_W = 24;
  localparam int HEAD_W    = 16;
  localparam int CNT_W     = 16;
  localparam int DPC_W     = 24;
  localparam int IWB_W     = 16;

  // Multiplier operand and product widths.
  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 32;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // Rotator datapath widths.
  localparam int XY_W = 64;
  localparam int Z_W  = 34;

  localparam logic signed [16:0] HEAD_PI     = 17'sd25736;
  localparam logic signed [16:0] HEAD_TWO_PI = 17'sd51472;
  localparam logic signed [Z_W-1:0] Z_PI      = 34'sd1686629713;
  localparam logic signed [Z_W-1:0] Z_HALF_PI = 34'sd843314857;
  localparam logic signed [MUL_B_W-1:0] GAIN_Q30 = 32'sd652032874;

  // Configuration register indexes.
  localparam logic REG_DIST_PER_COUNT = 1'b0;
  localparam logic REG_INV_WHEELBASE  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_SUM,
    ST_MUL_DIFF,
    ST_MUL_YAW,
    ST_MUL_GAIN,
    ST_LOAD,
    ST_ROT,
    ST_FINISH
  } ddo_state_t;

  typedef struct packed {
    logic load;
    logic run;
  } ddo_rot_ctl_t;

  typedef struct packed {
    logic last;
  } ddo_rot_sts_t;

  // Arctangent of 2^-i in 2^-29 rad.
  function automatic logic signed [Z_W-1:0] atan_lut(input logic [STEP_W-1:0] i);
    logic signed [Z_W-1:0] r;
    unique case (i)
      5'd0:  r = 34'sd421657428;
      5'd1:  r = 34'sd248918915;
      5'd2:  r = 34'sd131521918;
      5'd3:  r = 34'sd66762579;
      5'd4:  r = 34'sd33510843;
      5'd5:  r = 34'sd16771758;
      5'd6:  r = 34'sd8387925;
      5'd7:  r = 34'sd4194219;
      5'd8:  r = 34'sd2097141;
      5'd9:  r = 34'sd1048575;
      5'd10: r = 34'sd524288;
      5'd11: r = 34'sd262144;
      5'd12: r = 34'sd131072;
      5'd13: r = 34'sd65536;
      5'd14: r = 34'sd32768;
      5'd15: r = 34'sd16384;
      5'd16: r = 34'sd8192;
      5'd17: r = 34'sd4096;
      5'd18: r = 34'sd2048;
      5'd19: r = 34'sd1024;
      5'd20: r = 34'sd512;
      5'd21: r = 34'sd256;
      5'd22: r = 34'sd128;
      5'd23: r = 34'sd64;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Clamp to the 24-bit signed step range.
  function automatic logic signed [STEP_OUT_W-1:0] sat_step(input logic signed [63:0] v);
    logic signed [STEP_OUT_W-1:0] r;
    if (v > 64'sd8388607) begin
      r = 24'sh7FFFFF;
    end else if (v < -64'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = STEP_OUT_W'(v);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- design/diff_drive_odometry_step_core.sv -----
// Top level: differential-drive odometry step with sequencer and output register.
// The block takes one word at a time: after accepting one it stays busy until its result is
// registered. Each word makes four passes through the shared multiplier, then runs the CORDIC
// rotator, one micro-rotation per cycle.
// Reset (rst, synchronous, active high): idle, output empty, position accumulators zero,
// distance_per_count 8192, inverse_wheelbase 1280.
`default_nettype none
module diff_drive_odometry_step_core
  import ddo_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  // Configuration write port.
  input  wire logic         cfg_we,
  input  wire logic         cfg_addr,
  input  wire logic [23:0]  cfg_data,
  // Input stream.
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // left_step_count[15:0], right_step_count[31:16], heading_in[47:32]
  input  wire logic [47:0]  s_axis_tdata,
  // Output stream.
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // pos_x[39:0], pos_y[79:40], step_x[103:80], step_y[127:104],
  // yaw_step[151:128], heading_wrapped[167:152]
  output logic [167:0]      m_axis_tdata
);

  // Configuration registers.
  logic [DPC_W-1:0] dist_per_count;
  logic [IWB_W-1:0] inv_wheelbase;

  always_ff @(posedge clk) begin
    if (rst) begin
      dist_per_count <= 24'd8192;
      inv_wheelbase  <= 16'd1280;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_DIST_PER_COUNT: dist_per_count <= cfg_data;
        REG_INV_WHEELBASE:  inv_wheelbase  <= cfg_data[IWB_W-1:0];
        default: ;
      endcase
    end
  end

  ddo_state_t state;
  ddo_state_t state_next;

  logic in_fire;
  logic out_free;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  // Per-item working registers (payload, no reset).
  logic signed [CNT_W-1:0]      left_q;
  logic signed [CNT_W-1:0]      right_q;
  logic signed [HEAD_W-1:0]     head_q;
  logic signed [31:0]           fwd_q;
  logic signed [STEP_OUT_W-1:0] yaw_q;

  // Heading wrap on the incoming word.
  logic signed [16:0]      head_ext;
  logic signed [16:0]      head_wrap;

  assign head_ext = 17'(signed'(s_axis_tdata[47:32]));

  always_comb begin
    if (head_ext >= HEAD_PI) begin
      head_wrap = head_ext - HEAD_TWO_PI;
    end else if (head_ext <= -HEAD_PI) begin
      head_wrap = head_ext + HEAD_TWO_PI;
    end else begin
      head_wrap = head_ext;
    end
  end

  // Shared multiplier.
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] prod;

  ddo_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // Wheel sum and difference: the distance sum is one product, and the
  // distance difference times the inverse wheelbase is two chained products.
  logic signed [CNT_W:0]     wheel_sum;
  logic signed [CNT_W:0]     wheel_diff;
  logic signed [40:0]        dist_sum;
  logic                      opposite;
  logic signed [MUL_P_W-1:0] yaw_round;

  assign wheel_sum  = 17'(left_q) + 17'(right_q);
  assign wheel_diff = 17'(right_q) - 17'(left_q);
  assign dist_sum   = signed'(prod[40:0]) + 41'sd256;
  assign opposite   = (left_q < 0 && right_q > 0) || (left_q > 0 && right_q < 0);
  assign yaw_round  = prod + MUL_P_W'(32768);

  // CORDIC rotator.
  ddo_rot_ctl_t             rot_ctl;
  ddo_rot_sts_t             rot_sts;
  logic signed [XY_W-1:0]   rot_x;
  logic signed [XY_W-1:0]   rot_y;
  logic signed [Z_W-1:0]    rot_z0;

  assign rot_z0 = Z_W'(head_q) <<< 16;

  ddo_rot u_rot (
    .clk (clk),
    .rst (rst),
    .ctl (rot_ctl),
    .x0  (signed'(prod[XY_W-1:0])),
    .z0  (rot_z0),
    .x   (rot_x),
    .y   (rot_y),
    .sts (rot_sts)
  );

  // Round the rotated vector back to 2^-16 m and saturate.
  logic signed [XY_W-1:0]        x_round;
  logic signed [XY_W-1:0]        y_round;
  logic signed [STEP_OUT_W-1:0]  step_x;
  logic signed [STEP_OUT_W-1:0]  step_y;

  assign x_round = rot_x + XY_W'(64'sd536870912);
  assign y_round = rot_y + XY_W'(64'sd536870912);
  assign step_x  = sat_step(64'(signed'(x_round[XY_W-1:30])));
  assign step_y  = sat_step(64'(signed'(y_round[XY_W-1:30])));

  // Position accumulators, wrapping.
  logic signed [POSITION_BITS-1:0] x_acc;
  logic signed [POSITION_BITS-1:0] y_acc;
  logic signed [POSITION_BITS-1:0] x_acc_next;
  logic signed [POSITION_BITS-1:0] y_acc_next;

  assign x_acc_next = x_acc + POSITION_BITS'(step_x);
  assign y_acc_next = y_acc + POSITION_BITS'(step_y);

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (s_axis_tvalid) state_next = ST_MUL_SUM;
      ST_MUL_SUM:  state_next = ST_MUL_DIFF;
      ST_MUL_DIFF: state_next = ST_MUL_YAW;
      ST_MUL_YAW:  state_next = ST_MUL_GAIN;
      ST_MUL_GAIN: state_next = ST_LOAD;
      ST_LOAD:     state_next = ST_ROT;
      ST_ROT:      if (rot_sts.last) state_next = ST_FINISH;
      ST_FINISH:   if (out_free) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // Control outputs: multiplier operands and rotator commands.
  always_comb begin
    s_axis_tready = 1'b0;
    mul_a         = '0;
    mul_b         = '0;
    rot_ctl       = '0;
    unique case (state)
      ST_IDLE: s_axis_tready = 1'b1;
      ST_MUL_SUM: begin
        mul_a = MUL_A_W'(wheel_sum);
        mul_b = signed'(MUL_B_W'(dist_per_count));
      end
      ST_MUL_DIFF: begin
        mul_a = MUL_A_W'(wheel_diff);
        mul_b = signed'(MUL_B_W'(inv_wheelbase));
      end
      ST_MUL_YAW: begin
        // Feed the difference-times-wheelbase product back in.
        mul_a = signed'(prod[MUL_A_W-1:0]);
        mul_b = signed'(MUL_B_W'(dist_per_count));
      end
      ST_MUL_GAIN: begin
        mul_a = MUL_A_W'(fwd_q);
        mul_b = GAIN_Q30;
      end
      ST_LOAD:   rot_ctl.load = 1'b1;
      ST_ROT:    rot_ctl.run  = 1'b1;
      ST_FINISH: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Capture item fields and intermediate results as the sequence advances.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      left_q  <= signed'(s_axis_tdata[15:0]);
      right_q <= signed'(s_axis_tdata[31:16]);
      head_q  <= HEAD_W'(head_wrap);
    end
    if (state == ST_MUL_DIFF) begin
      // Drop the forward step when the wheels turn in opposite directions.
      fwd_q <= opposite ? '0 : signed'(dist_sum[40:9]);
    end
    if (state == ST_MUL_GAIN) begin
      yaw_q <= sat_step(64'(signed'(yaw_round[MUL_P_W-1:16])));
    end
  end

  // Accumulators and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      x_acc         <= '0;
      y_acc         <= '0;
      m_axis_tvalid <= 1'b0;
    end else if (state == ST_FINISH && out_free) begin
      x_acc         <= x_acc_next;
      y_acc         <= y_acc_next;
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && out_free) begin
      m_axis_tdata <= {head_q, yaw_q, step_y, step_x,
                       POS_OUT_W'(y_acc_next), POS_OUT_W'(x_acc_next)};
    end
  end

endmodule
`default_nettype wire

// ----- design/ddo_mul.sv -----
// Shared signed multiplier with a registered product.
`default_nettype none
module ddo_mul
  import ddo_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic signed [MUL_A_W-1:0] a,
  input  wire logic signed [MUL_B_W-1:0] b,
  output logic signed [MUL_P_W-1:0]      p
);

  always_ff @(posedge clk) begin
    p <= MUL_P_W'(a) * MUL_P_W'(b);
  end

endmodule
`default_nettype wire

// ----- design/ddo_rot.sv -----
// Iterative CORDIC rotator: one shift-add micro-rotation per cycle while ctl.run is high.
`default_nettype none
module ddo_rot
  import ddo_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire ddo_rot_ctl_t           ctl,
  input  wire logic signed [XY_W-1:0] x0,
  input  wire logic signed [Z_W-1:0]  z0,
  output logic signed [XY_W-1:0]      x,
  output logic signed [XY_W-1:0]      y,
  output ddo_rot_sts_t                sts
);

  logic signed [Z_W-1:0]  z;
  logic [STEP_W-1:0]      cnt;
  logic signed [XY_W-1:0] xs;
  logic signed [XY_W-1:0] ys;
  logic signed [Z_W-1:0]  ang;

  assign xs  = x >>> cnt;
  assign ys  = y >>> cnt;
  assign ang = atan_lut(cnt);
  assign sts.last = (cnt == STEP_W'(ROT_STEPS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (ctl.load) begin
      cnt <= '0;
    end else if (ctl.run) begin
      cnt <= cnt + 1'b1;
    end
  end

  // Fold the angle into +-pi/2 on load, then rotate toward z = 0.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      y <= '0;
      if (z0 > Z_HALF_PI) begin
        z <= z0 - Z_PI;
        x <= -x0;
      end else if (z0 < -Z_HALF_PI) begin
        z <= z0 + Z_PI;
        x <= -x0;
      end else begin
        z <= z0;
        x <= x0;
      end
    end else if (ctl.run) begin
      if (z >= 0) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - ang;
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + ang;
      end
    end
  end

endmodule
`default_nettype wire

// ----- design/diff_drive_odometry_step_core_checker.sv -----
// Port-level checker for the odometry step block, bound to the top level.
`default_nettype none
`include "diff_drive_odometry_step_core_defines.svh"
module diff_drive_odometry_step_core_checker (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         s_axis_tvalid,
  input wire logic         s_axis_tready,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [167:0] m_axis_tdata
);

  // Busy right after taking a word.
  `DDO_ASSERT_NEXT(a_busy_after_accept, clk, rst, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken while busy")

  // A new result appears only at the end of a busy stretch.
  `DDO_ASSERT_NOW(a_result_after_busy, clk, rst, $rose(m_axis_tvalid), !$past(s_axis_tready), "result without work")

  // Hold a stalled result.
  `DDO_ASSERT_NEXT(a_hold_stalled, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

endmodule

bind diff_drive_odometry_step_core diff_drive_odometry_step_core_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

// ----- verif/tb_diff_drive_odometry_step_core.sv -----
// Self-checking testbench for the differential-drive odometry step core.
module tb_diff_drive_odometry_step_core;
  import ddo_pkg::*;

  // Fixed-point constants of the odometry math (Q3.13 heading, 2^-29 rad angle).
  localparam longint HALF_TURN_Q13    = 25736;
  localparam longint FULL_TURN_Q13    = 51472;
  localparam longint QUARTER_TURN_Z   = 843314857;
  localparam longint HALF_TURN_Z      = 1686629713;
  localparam longint CORDIC_GAIN_Q30  = 652032874;
  localparam int     ARCTAN_ENTRIES   = 24;
  localparam int     HOLD_OFF_CYCLES  = 300;
  localparam int     SAT_RUN_WORDS    = 40;
  localparam int     RANDOM_PHASES    = 6;
  localparam int     WORDS_PER_PHASE  = 180;
  localparam int     MAX_REPORTS      = 50;

  // One result word, laid out so that it maps straight onto m_axis_tdata.
  typedef struct packed {
    logic signed [15:0] heading_wrapped;
    logic signed [23:0] yaw_step;
    logic signed [23:0] step_y;
    logic signed [23:0] step_x;
    logic signed [39:0] pos_y;
    logic signed [39:0] pos_x;
  } odo_word_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_we = 1'b0;
  logic         cfg_addr = REG_DIST_PER_COUNT;
  logic [23:0]  cfg_data = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // left_step_count[15:0], right_step_count[31:16], heading_in[47:32]
  logic [47:0]  s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // pos_x[39:0], pos_y[79:40], step_x[103:80], step_y[127:104],
  // yaw_step[151:128], heading_wrapped[167:152]
  logic [167:0] m_axis_tdata;

  // Arctangent of 2^-i, in 2^-29 rad.
  longint arctan_z [0:ARCTAN_ENTRIES-1] = '{
    421657428, 248918915, 131521918, 66762579, 33510843, 16771758,
    8387925, 4194219, 2097141, 1048575, 524288, 262144,
    131072, 65536, 32768, 16384, 8192, 4096,
    2048, 1024, 512, 256, 128, 64
  };

  // Shadow of the block's registers and position accumulators.
  logic [23:0]              dist_per_count_q = 24'd8192;
  logic [15:0]              inv_wheelbase_q  = 16'd1280;
  logic [POSITION_BITS-1:0] x_pos_acc = '0;
  logic [POSITION_BITS-1:0] y_pos_acc = '0;

  // Predicted result words, oldest first.
  odo_word_t pending_words[$];

  int failures      = 0;
  int items_sent    = 0;
  int words_checked = 0;
  int reg_writes    = 0;

  // Idling knobs: upper bound of the per-word gap on each side.
  int tx_gap_max = 0;
  int rx_gap_max = 0;
  int rx_stall   = 0;
  int rx_hold_cycles = 0;

  diff_drive_odometry_step_core DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Clamp to the 24-bit signed step range.
  function automatic logic signed [23:0] clamp_step(input longint v);
    if (v > 8388607) begin
      return 24'sh7FFFFF;
    end
    if (v < -8388608) begin
      return 24'sh800000;
    end
    return v[23:0];
  endfunction

  // Compute the result word of one input word and advance the accumulators.
  function automatic odo_word_t advance_odometry(input logic signed [15:0] left,
                                                 input logic signed [15:0] right,
                                                 input logic signed [15:0] heading);
    longint dl, dr, fwd, x, y, z, xs, ys, hw;
    logic signed [23:0] sx, sy;
    odo_word_t w;
    dl = longint'(left) * longint'(dist_per_count_q);
    dr = longint'(right) * longint'(dist_per_count_q);
    // Average the wheel travel into 2^-16 m, rounded; drop it on a spin.
    fwd = (dl + dr + 256) >>> 9;
    if ((dl < 0 && dr > 0) || (dl > 0 && dr < 0)) begin
      fwd = 0;
    end
    w.yaw_step = clamp_step(((dr - dl) * longint'(inv_wheelbase_q) + 32768) >>> 16);
    // Wrap the heading once into [-pi, pi].
    hw = longint'(heading);
    if (hw >= HALF_TURN_Q13) begin
      hw = hw - FULL_TURN_Q13;
    end else if (hw <= -HALF_TURN_Q13) begin
      hw = hw + FULL_TURN_Q13;
    end
    w.heading_wrapped = hw[15:0];
    // Fold the angle into [-pi/2, pi/2], then rotate the gain-compensated step.
    x = fwd * CORDIC_GAIN_Q30;
    y = 0;
    z = hw * 65536;
    if (z > QUARTER_TURN_Z) begin
      z = z - HALF_TURN_Z;
      x = -x;
    end else if (z < -QUARTER_TURN_Z) begin
      z = z + HALF_TURN_Z;
      x = -x;
    end
    for (int i = 0; i < CORDIC_STEPS && i < ARCTAN_ENTRIES; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - arctan_z[i];
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + arctan_z[i];
      end
    end
    sx = clamp_step((x + (longint'(1) <<< 29)) >>> 30);
    sy = clamp_step((y + (longint'(1) <<< 29)) >>> 30);
    // Accumulate the saturated steps; the accumulators wrap.
    x_pos_acc = x_pos_acc + POSITION_BITS'(longint'(sx));
    y_pos_acc = y_pos_acc + POSITION_BITS'(longint'(sy));
    w.pos_x  = 40'($signed(x_pos_acc));
    w.pos_y  = 40'($signed(y_pos_acc));
    w.step_x = sx;
    w.step_y = sy;
    return w;
  endfunction

  task automatic report_failure(input string msg);
    failures++;
    // Keep the log short when the block is badly broken.
    if (failures <= MAX_REPORTS) begin
      $display("ERROR at %0t, word %0d: %s", $time, words_checked, msg);
    end
  endtask

  task automatic check_field(input string name, input logic signed [63:0] got_v,
                             input logic signed [63:0] want_v);
    if (got_v !== want_v) begin
      report_failure($sformatf("%s got %0d, expected %0d", name, got_v, want_v));
    end
  endtask

  // Offer one input word after a random gap; predict it once accepted.
  // Leave tvalid high so that a back-to-back word keeps it up.
  task automatic send_word(input logic signed [15:0] left, input logic signed [15:0] right,
                           input logic signed [15:0] heading);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    @(negedge clk);
    if (gap != 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tdata  = {heading, right, left};
    s_axis_tvalid = 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    pending_words.push_back(advance_odometry(left, right, heading));
    items_sent++;
  endtask

  // Drop tvalid and hold until every predicted word has come out.
  task automatic wait_drained();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
  endtask

  // Write a register; only done with the block empty.
  task automatic write_reg(input logic addr, input logic [23:0] value);
    wait_drained();
    @(negedge clk);
    cfg_we   = 1'b1;
    cfg_addr = addr;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
    if (addr == REG_DIST_PER_COUNT) begin
      dist_per_count_q = value;
    end else begin
      inv_wheelbase_q = value[15:0];
    end
    reg_writes++;
  endtask

  function automatic logic signed [15:0] draw_count();
    logic signed [15:0] c;
    case ($urandom_range(0, 3))
      0: c = 16'($urandom());
      1: c = 16'($urandom_range(0, 400) - 200);
      2: begin
        case ($urandom_range(0, 4))
          0: c = 16'sh7FFF;
          1: c = 16'sh8000;
          2: c = 16'sd0;
          3: c = 16'sd1;
          default: c = -16'sd1;
        endcase
      end
      default: c = 16'($urandom_range(0, 4095) - 2048);
    endcase
    return c;
  endfunction

  function automatic logic [23:0] draw_dist_per_count();
    case ($urandom_range(0, 3))
      0: return ($urandom_range(0, 1) != 0) ? 24'hFFFFFF : 24'd1;
      1: return 24'($urandom_range(1, 24'hFFFFFF));
      2: return 24'($urandom_range(4096, 65536));
      default: return 24'($urandom_range(1, 255));
    endcase
  endfunction

  function automatic logic [23:0] draw_inv_wheelbase();
    case ($urandom_range(0, 3))
      0: return ($urandom_range(0, 1) != 0) ? 24'h00FFFF : 24'd1;
      1: return 24'($urandom_range(1, 16'hFFFF));
      2: return 24'($urandom_range(256, 4096));
      default: return 24'($urandom_range(1, 255));
    endcase
  endfunction

  // Receiver: drive tready from the long hold-off first, then the per-word stall.
  initial begin
    forever begin
      @(negedge clk);
      if (rx_hold_cycles > 0) begin
        m_axis_tready = 1'b0;
        rx_hold_cycles--;
      end else if (rx_stall > 0) begin
        m_axis_tready = 1'b0;
        rx_stall--;
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  // Compare every accepted result word with the oldest prediction.
  always @(posedge clk) begin : check_words
    odo_word_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      rx_stall = $urandom_range(0, rx_gap_max);
      if (pending_words.size() == 0) begin
        report_failure("result word with no input word pending");
      end else begin
        want = pending_words.pop_front();
        check_field("pos_x", got.pos_x, want.pos_x);
        check_field("pos_y", got.pos_y, want.pos_y);
        check_field("step_x", got.step_x, want.step_x);
        check_field("step_y", got.step_y, want.step_y);
        check_field("yaw_step", got.yaw_step, want.yaw_step);
        check_field("heading_wrapped", got.heading_wrapped, want.heading_wrapped);
      end
      words_checked++;
    end
  end

  // Field extremes, spin and one-wheel moves, and headings around every wrap
  // and fold boundary, all at the reset register values.
  task automatic test_directed_fields();
    tx_gap_max = 15;
    rx_gap_max = 15;
    send_word(16'sd0, 16'sd0, 16'sd0);
    send_word(16'sh7FFF, 16'sh7FFF, 16'sd0);
    send_word(16'sh8000, 16'sh8000, 16'sd0);
    send_word(16'sh7FFF, 16'sh8000, 16'sd0);
    send_word(16'sh8000, 16'sh7FFF, 16'sd6434);
    send_word(16'sd1000, 16'sd0, 16'sd0);
    send_word(-16'sd1, 16'sd1, 16'sd0);
    send_word(16'sd500, 16'sd500, 16'sh7FFF);
    send_word(16'sd500, 16'sd500, 16'sh8000);
    send_word(16'sd500, 16'sd500, 16'sd25736);
    send_word(16'sd500, 16'sd500, 16'sd25735);
    send_word(16'sd500, 16'sd500, -16'sd25736);
    send_word(16'sd500, 16'sd500, -16'sd25735);
    send_word(16'sd500, 16'sd500, 16'sd12868);
    send_word(16'sd500, 16'sd500, 16'sd12867);
    send_word(-16'sd500, -16'sd500, -16'sd12868);
    send_word(-16'sd500, -16'sd500, -16'sd12867);
  endtask

  // Largest, zero and unit register values; saturated steps and yaw.
  task automatic test_register_extremes();
    write_reg(REG_DIST_PER_COUNT, 24'hFFFFFF);
    write_reg(REG_INV_WHEELBASE, 24'h00FFFF);
    send_word(16'sh7FFF, 16'sh7FFF, 16'sd6434);
    send_word(16'sh8000, 16'sh8000, -16'sd6434);
    send_word(16'sh7FFF, 16'sh8000, 16'sd0);
    send_word(16'sh8000, 16'sh7FFF, 16'sd20000);
    write_reg(REG_DIST_PER_COUNT, 24'd0);
    write_reg(REG_INV_WHEELBASE, 24'd0);
    send_word(16'sh7FFF, 16'sh8000, 16'sd1234);
    write_reg(REG_DIST_PER_COUNT, 24'd1);
    // Upper data bits beyond the register width are dropped.
    write_reg(REG_INV_WHEELBASE, 24'hA50001);
    send_word(16'sd1, 16'sd0, 16'sd0);
    send_word(-16'sd1, -16'sd1, 16'sd3000);
    send_word(16'sh8000, 16'sh7FFF, -16'sd3000);
  endtask

  // Drive saturated diagonal steps back to back into the accumulators.
  task automatic test_saturated_run();
    write_reg(REG_DIST_PER_COUNT, 24'hFFFFFF);
    write_reg(REG_INV_WHEELBASE, 24'd1280);
    tx_gap_max = 0;
    rx_gap_max = 0;
    repeat (SAT_RUN_WORDS) send_word(16'sh7FFF, 16'sh7FFF, 16'sd6434);
    wait_drained();
  endtask

  // Stall the output long enough for the block to fill and stall its input.
  task automatic test_output_backpressure();
    tx_gap_max = 0;
    rx_gap_max = 0;
    rx_hold_cycles = HOLD_OFF_CYCLES;
    repeat (12) send_word(draw_count(), draw_count(), 16'($urandom()));
    wait_drained();
  endtask

  // Random words over several register settings and idling mixes.
  task automatic test_random_traffic();
    logic signed [15:0] left, right;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      write_reg(REG_DIST_PER_COUNT, draw_dist_per_count());
      write_reg(REG_INV_WHEELBASE, draw_inv_wheelbase());
      tx_gap_max = (phase % 4 == 0 || phase % 4 == 1) ? 15 : 0;
      rx_gap_max = (phase % 4 == 0 || phase % 4 == 2) ? 15 : 0;
      repeat (WORDS_PER_PHASE) begin
        left = draw_count();
        case ($urandom_range(0, 3))
          0: right = left + 16'($urandom_range(0, 64) - 32);
          1: right = -left;
          default: right = draw_count();
        endcase
        send_word(left, right, 16'($urandom()));
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_fields();
    test_register_extremes();
    test_output_backpressure();
    test_saturated_run();
    test_random_traffic();

    // Let the last words out, then watch for strays.
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    for (int n = 0; n < 5000 && pending_words.size() != 0; n++) @(posedge clk);
    repeat (40) @(posedge clk);
    if (pending_words.size() != 0) begin
      report_failure($sformatf("%0d predicted words never came out", pending_words.size()));
    end

    $display("Run covered %0d input words, %0d result words and %0d register writes,",
             items_sent, words_checked, reg_writes);
    $display("with a run of saturated steps and a %0d-cycle output stall.",
             HOLD_OFF_CYCLES);
    if (failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #200_000_000;
    $display("Timeout with %0d words still pending", pending_words.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ----- diff_drive_odometry_step_core.f -----
+incdir+design
design/ddo_pkg.sv
design/ddo_mul.sv
design/ddo_rot.sv
design/diff_drive_odometry_step_core.sv
design/diff_drive_odometry_step_core_checker.sv
verif/tb_diff_drive_odometry_step_core.sv
